// ----- hw/rtl/bbps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbps_pkg: shared definitions for the bouncing ball perspective block
// widths, register indexes, reset values and saturation helpers
// ----------------------------------------------------------------------------
package bbps_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned VelInW = 10;
  localparam int unsigned WallW  = 10;
  localparam int unsigned RadW   = 8;
  localparam int unsigned FlW    = 10;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned ScrW   = 18;
  localparam int unsigned NumW   = 29;
  localparam int unsigned DenW   = 17;

  localparam int unsigned ScreenWidth  = 400;
  localparam int unsigned ScreenHeight = 400;

  localparam logic signed [21:0] CenterX = 22'(ScreenWidth * 32);
  localparam logic signed [21:0] CenterY = 22'(ScreenHeight * 32);

  localparam logic [WallW-1:0] WallLowRst  = 10'h39C;
  localparam logic [WallW-1:0] WallHighRst = 10'd100;
  localparam logic [RadW-1:0]  RadiusRst   = 8'd40;
  localparam logic [FlW-1:0]   FocalRst    = 10'd250;

  typedef enum logic [2:0] {
    CFG_WALL_LEFT   = 3'd0,
    CFG_WALL_RIGHT  = 3'd1,
    CFG_WALL_TOP    = 3'd2,
    CFG_WALL_BOTTOM = 3'd3,
    CFG_WALL_FRONT  = 3'd4,
    CFG_WALL_BACK   = 3'd5,
    CFG_RADIUS      = 3'd6,
    CFG_FOCAL       = 3'd7
  } cfg_idx_e;

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[PosW-1:0];
  endfunction

  function automatic logic signed [ScrW-1:0] sat_scr(input logic signed [21:0] v);
    if (v > 22'sd131071) begin
      return 18'sh1FFFF;
    end else if (v < -22'sd131072) begin
      return 18'sh20000;
    end
    return v[ScrW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bbps_move.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbps_move: one-axis motion step
// adds velocity to position, tests both walls, clamps and reflects
// ----------------------------------------------------------------------------
module bbps_move (
  input  wire logic signed [bbps_pkg::PosW-1:0]  pos_i,
  input  wire logic signed [bbps_pkg::PosW-1:0]  vel_i,
  input  wire logic signed [bbps_pkg::WallW-1:0] lo_i,
  input  wire logic signed [bbps_pkg::WallW-1:0] hi_i,
  input  wire logic        [bbps_pkg::RadW-1:0]  radius_i,
  output logic signed      [bbps_pkg::PosW-1:0]  pos_o,
  output logic signed      [bbps_pkg::PosW-1:0]  vel_o
);

  logic signed [18:0] sum_w, r_w, lo_w, hi_w, p_w;
  logic signed [16:0] nv_w;
  logic signed [bbps_pkg::PosW-1:0] vneg_w;

  always_comb begin
    sum_w  = 19'(pos_i) + 19'(vel_i);
    r_w    = $signed({5'b0, radius_i, 6'b0});
    lo_w   = $signed({{3{lo_i[bbps_pkg::WallW-1]}}, lo_i, 6'b0});
    hi_w   = $signed({{3{hi_i[bbps_pkg::WallW-1]}}, hi_i, 6'b0});
    nv_w   = -17'(vel_i);
    vneg_w = (nv_w > 17'sd32767) ? 16'sh7FFF : nv_w[bbps_pkg::PosW-1:0];
    p_w    = sum_w;
    vel_o  = vel_i;
    if ((sum_w + r_w) > hi_w) begin
      p_w   = hi_w - r_w;
      vel_o = vneg_w;
    end else if ((sum_w - r_w) < lo_w) begin
      p_w   = lo_w + r_w;
      vel_o = vneg_w;
    end
    pos_o = bbps_pkg::sat_pos(p_w);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bbps_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbps_div: iterative restoring divider for the perspective scale
// one quotient bit per cycle, saturates when the quotient exceeds 16 bits
// ----------------------------------------------------------------------------
module bbps_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [bbps_pkg::NumW-1:0]     num_i,
  input  wire logic [bbps_pkg::DenW-1:0]     den_i,
  output logic                               done_o,
  output logic [bbps_pkg::ScaleW-1:0]        quot_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [3:0]                        cnt_q;
  logic [bbps_pkg::DenW-1:0]         den_q;
  logic [bbps_pkg::DenW-1:0]         rem_q;
  logic [bbps_pkg::ScaleW-1:0]       sh_q;
  logic [bbps_pkg::DenW:0]           rem2_w;
  logic [bbps_pkg::DenW:0]           diff_w;
  logic                              qbit_w;
  logic [bbps_pkg::DenW-1:0]         rem_d;

  always_comb begin
    rem2_w = {rem_q, sh_q[bbps_pkg::ScaleW-1]};
    qbit_w = rem2_w >= {1'b0, den_q};
    diff_w = rem2_w - {1'b0, den_q};
    rem_d  = qbit_w ? diff_w[bbps_pkg::DenW-1:0] : rem2_w[bbps_pkg::DenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
    end else if (start_i) begin
      den_q <= den_i;
      if ({4'b0, num_i[bbps_pkg::NumW-1:bbps_pkg::ScaleW]} >= den_i) begin
        sh_q   <= '1;
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        rem_q  <= {4'b0, num_i[bbps_pkg::NumW-1:bbps_pkg::ScaleW]};
        sh_q   <= num_i[bbps_pkg::ScaleW-1:0];
        cnt_q  <= '0;
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[bbps_pkg::ScaleW-2:0], qbit_w};
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bounce_box_perspective_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounce_box_perspective_step: bouncing ball in a 3D box with perspective view
// each item is a tick or a launch; one result item per input item
// ----------------------------------------------------------------------------
// A tick item steps through the shared axis motion unit (x, y, z), forms
// the divisor, runs the bit-serial scale divider, uses the shared multiplier
// on the x and y projections, and hands the result to the output register.
// The next item is accepted only after that hand-over. A launch skips the
// motion steps; an invisible ball skips divide and multiply. in_stall_o is
// high while an item is in work; the next item is taken while the previous
// result still waits.
module bounce_box_perspective_step (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [2:0]                          cfg_index_i,
  input  wire logic [bbps_pkg::CfgW-1:0]           cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                action_i,
  input  wire logic signed [bbps_pkg::VelInW-1:0]  launch_vel_x_i,
  input  wire logic signed [bbps_pkg::VelInW-1:0]  launch_vel_y_i,
  input  wire logic signed [bbps_pkg::VelInW-1:0]  launch_vel_z_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     visible_o,
  output logic signed [bbps_pkg::ScrW-1:0]         screen_x_o,
  output logic signed [bbps_pkg::ScrW-1:0]         screen_y_o,
  output logic        [bbps_pkg::ScaleW-1:0]       draw_scale_o,
  output logic signed [bbps_pkg::PosW-1:0]         depth_z_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PROJ,
    S_DIV,
    S_MUL,
    S_ADD,
    S_DONE
  } state_e;

  logic [bbps_pkg::WallW-1:0] wall_left_q, wall_right_q, wall_top_q;
  logic [bbps_pkg::WallW-1:0] wall_bottom_q, wall_front_q, wall_back_q;
  logic [bbps_pkg::RadW-1:0]  radius_q;
  logic [bbps_pkg::FlW-1:0]   focal_q;

  state_e state_q;
  logic [1:0] axis_q;
  logic       msel_q;
  logic signed [bbps_pkg::PosW-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [bbps_pkg::PosW-1:0] vel_x_q, vel_y_q, vel_z_q;
  logic                              vis_q;
  logic [bbps_pkg::ScaleW-1:0]       scale_q;
  logic signed [bbps_pkg::ScrW-1:0]  scr_x_q, scr_y_q;
  logic signed [32:0]                prod_q;

  logic                              out_valid_q;
  logic                              out_vis_q;
  logic signed [bbps_pkg::ScrW-1:0]  out_x_q, out_y_q;
  logic [bbps_pkg::ScaleW-1:0]       out_scale_q;
  logic signed [bbps_pkg::PosW-1:0]  out_z_q;

  logic signed [bbps_pkg::PosW-1:0]  mv_pos_w, mv_vel_w, mv_pos_n, mv_vel_n;
  logic signed [bbps_pkg::WallW-1:0] mv_lo_w, mv_hi_w;

  logic [15:0]                fl64_w;
  logic signed [17:0]         zsum_w;
  logic                       vis_w;
  logic [bbps_pkg::DenW-1:0]  den_w;
  logic [bbps_pkg::NumW-1:0]  num_w;
  logic                       div_start;
  logic                       div_done;
  logic [bbps_pkg::ScaleW-1:0] div_quot;

  logic signed [bbps_pkg::PosW-1:0] mul_a_w;
  logic signed [32:0]               prod_d;
  logic signed [32:0]               rnd_w;
  logic signed [21:0]               scr_w;
  logic signed [bbps_pkg::ScrW-1:0] scr_sat_w;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_left_q   <= bbps_pkg::WallLowRst;
      wall_right_q  <= bbps_pkg::WallHighRst;
      wall_top_q    <= bbps_pkg::WallLowRst;
      wall_bottom_q <= bbps_pkg::WallHighRst;
      wall_front_q  <= bbps_pkg::WallLowRst;
      wall_back_q   <= bbps_pkg::WallHighRst;
      radius_q      <= bbps_pkg::RadiusRst;
      focal_q       <= bbps_pkg::FocalRst;
    end else if (cfg_we_i) begin
      case (bbps_pkg::cfg_idx_e'(cfg_index_i))
        bbps_pkg::CFG_WALL_LEFT:   wall_left_q   <= cfg_wdata_i;
        bbps_pkg::CFG_WALL_RIGHT:  wall_right_q  <= cfg_wdata_i;
        bbps_pkg::CFG_WALL_TOP:    wall_top_q    <= cfg_wdata_i;
        bbps_pkg::CFG_WALL_BOTTOM: wall_bottom_q <= cfg_wdata_i;
        bbps_pkg::CFG_WALL_FRONT:  wall_front_q  <= cfg_wdata_i;
        bbps_pkg::CFG_WALL_BACK:   wall_back_q   <= cfg_wdata_i;
        bbps_pkg::CFG_RADIUS:      radius_q      <= cfg_wdata_i[bbps_pkg::RadW-1:0];
        bbps_pkg::CFG_FOCAL:       focal_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // shared axis unit input select
  always_comb begin
    case (axis_q)
      2'd0: begin
        mv_pos_w = pos_x_q;
        mv_vel_w = vel_x_q;
        mv_lo_w  = $signed(wall_left_q);
        mv_hi_w  = $signed(wall_right_q);
      end
      2'd1: begin
        mv_pos_w = pos_y_q;
        mv_vel_w = vel_y_q;
        mv_lo_w  = $signed(wall_top_q);
        mv_hi_w  = $signed(wall_bottom_q);
      end
      default: begin
        mv_pos_w = pos_z_q;
        mv_vel_w = vel_z_q;
        mv_lo_w  = $signed(wall_front_q);
        mv_hi_w  = $signed(wall_back_q);
      end
    endcase
  end

  bbps_move u_move (
    .pos_i    (mv_pos_w),
    .vel_i    (mv_vel_w),
    .lo_i     (mv_lo_w),
    .hi_i     (mv_hi_w),
    .radius_i (radius_q),
    .pos_o    (mv_pos_n),
    .vel_o    (mv_vel_n)
  );

  // visibility and divider operands
  always_comb begin
    fl64_w    = {focal_q, 6'b0};
    zsum_w    = $signed({2'b0, fl64_w}) + 18'(pos_z_q);
    vis_w     = zsum_w > 18'sd0;
    den_w     = zsum_w[bbps_pkg::DenW-1:0];
    num_w     = {1'b0, fl64_w, 12'b0} + 29'(den_w >> 1);
    div_start = (state_q == S_PROJ) && vis_w;
  end

  bbps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_w),
    .den_i   (den_w),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // shared multiplier and rounding
  always_comb begin
    mul_a_w   = msel_q ? pos_y_q : pos_x_q;
    prod_d    = 33'(mul_a_w) * 33'($signed({1'b0, scale_q}));
    rnd_w     = prod_q + 33'sd2048;
    scr_w     = 22'($signed(rnd_w[32:12])) + (msel_q ? bbps_pkg::CenterY : bbps_pkg::CenterX);
    scr_sat_w = bbps_pkg::sat_scr(scr_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      msel_q      <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      vel_z_q     <= '0;
      vis_q       <= 1'b0;
      scale_q     <= '0;
      scr_x_q     <= '0;
      scr_y_q     <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_vis_q   <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_scale_q <= '0;
      out_z_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            axis_q <= '0;
            if (action_i) begin
              pos_x_q <= '0;
              pos_y_q <= '0;
              pos_z_q <= '0;
              vel_x_q <= 16'(launch_vel_x_i);
              vel_y_q <= 16'(launch_vel_y_i);
              vel_z_q <= 16'(launch_vel_z_i);
              state_q <= S_PROJ;
            end else begin
              state_q <= S_MOVE;
            end
          end
        end
        S_MOVE: begin
          case (axis_q)
            2'd0: begin
              pos_x_q <= mv_pos_n;
              vel_x_q <= mv_vel_n;
            end
            2'd1: begin
              pos_y_q <= mv_pos_n;
              vel_y_q <= mv_vel_n;
            end
            default: begin
              pos_z_q <= mv_pos_n;
              vel_z_q <= mv_vel_n;
            end
          endcase
          axis_q <= axis_q + 2'd1;
          if (axis_q == 2'd2) begin
            state_q <= S_PROJ;
          end
        end
        S_PROJ: begin
          vis_q <= vis_w;
          if (vis_w) begin
            state_q <= S_DIV;
          end else begin
            scale_q <= '0;
            scr_x_q <= '0;
            scr_y_q <= '0;
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            scale_q <= div_quot;
            msel_q  <= 1'b0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= prod_d;
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (!msel_q) begin
            scr_x_q <= scr_sat_w;
            msel_q  <= 1'b1;
            state_q <= S_MUL;
          end else begin
            scr_y_q <= scr_sat_w;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_vis_q   <= vis_q;
            out_x_q     <= scr_x_q;
            out_y_q     <= scr_y_q;
            out_scale_q <= scale_q;
            out_z_q     <= pos_z_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign visible_o    = out_vis_q;
  assign screen_x_o   = out_x_q;
  assign screen_y_o   = out_y_q;
  assign draw_scale_o = out_scale_q;
  assign depth_z_o    = out_z_q;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bouncing ball perspective block
// launch and tick items are sent through a randomly idling driver. A shadow
// model of the box walls, the ball state and the perspective projection
// predicts every result item. The monitor, behind a randomly stalling
// receiver, checks each result field by field against the oldest prediction.
// Several wall, radius and focal settings are run, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  import bbps_pkg::*;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_LAUNCH = 1'b1;
  localparam int   IDLE_LIMIT = 4000;
  localparam int   DRAIN_WAIT = 40;
  localparam int   RAND_PHASES = 10;
  localparam int   PHASE_ITEMS = 95;

  typedef struct {
    logic                     action;
    logic signed [VelInW-1:0] vx;
    logic signed [VelInW-1:0] vy;
    logic signed [VelInW-1:0] vz;
  } ball_cmd_t;

  typedef struct {
    logic                     visible;
    logic signed [ScrW-1:0]   sx;
    logic signed [ScrW-1:0]   sy;
    logic        [ScaleW-1:0] scale;
    logic signed [PosW-1:0]   depth;
  } ball_view_t;

  typedef logic [CfgW-1:0] cfg_set_t [8];

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we = 1'b0;
  cfg_idx_e                 cfg_index = CFG_WALL_LEFT;
  logic [CfgW-1:0]          cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall_o;
  logic                     action = ACT_TICK;
  logic signed [VelInW-1:0] launch_vel_x = '0;
  logic signed [VelInW-1:0] launch_vel_y = '0;
  logic signed [VelInW-1:0] launch_vel_z = '0;
  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  logic                     visible_o;
  logic signed [ScrW-1:0]   screen_x_o;
  logic signed [ScrW-1:0]   screen_y_o;
  logic [ScaleW-1:0]        draw_scale_o;
  logic signed [PosW-1:0]   depth_z_o;

  // shadow registers and ball state, index 0..2 = x, y, z
  logic [WallW-1:0] wall_lo [3] = '{WallLowRst, WallLowRst, WallLowRst};
  logic [WallW-1:0] wall_hi [3] = '{WallHighRst, WallHighRst, WallHighRst};
  logic [RadW-1:0]  radius_q = RadiusRst;
  logic [FlW-1:0]   focal_q = FocalRst;
  longint           ball_pos [3] = '{0, 0, 0};
  longint           ball_vel [3] = '{0, 0, 0};

  ball_cmd_t  pending_cmds [$];
  ball_view_t predicted_views [$];
  ball_cmd_t  cur_cmd;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         no_idle = 1'b0;
  int         errors = 0;
  int         idle_cycles = 0;

  bounce_box_perspective_step u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .action_i       (action),
    .launch_vel_x_i (launch_vel_x),
    .launch_vel_y_i (launch_vel_y),
    .launch_vel_z_i (launch_vel_z),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .visible_o      (visible_o),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .draw_scale_o   (draw_scale_o),
    .depth_z_o      (depth_z_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [ScrW-1:0] project_axis(longint pos, longint scale,
                                                         longint center);
    return ScrW'(clip(center + ((pos * scale + 2048) >>> 12), -131072, 131071));
  endfunction

  function automatic ball_view_t predict_view(ball_cmd_t c);
    ball_view_t v;
    longint     r;
    longint     lo;
    longint     hi;
    longint     p;
    longint     fl64;
    longint     den;
    longint     scale;
    fl64 = longint'(focal_q) * 64;
    if (c.action == ACT_LAUNCH) begin
      ball_pos = '{0, 0, 0};
      ball_vel[0] = longint'(c.vx);
      ball_vel[1] = longint'(c.vy);
      ball_vel[2] = longint'(c.vz);
    end else begin
      r = longint'(radius_q) * 64;
      for (int a = 0; a < 3; a++) begin
        lo = longint'($signed(wall_lo[a])) * 64;
        hi = longint'($signed(wall_hi[a])) * 64;
        p = ball_pos[a] + ball_vel[a];
        // high wall is tested first and wins on an inverted box
        if (p + r > hi) begin
          p = hi - r;
          ball_vel[a] = clip(-ball_vel[a], -32768, 32767);
        end else if (p - r < lo) begin
          p = lo + r;
          ball_vel[a] = clip(-ball_vel[a], -32768, 32767);
        end
        ball_pos[a] = clip(p, -32768, 32767);
      end
    end
    if (ball_pos[2] > -fl64) begin
      den = fl64 + ball_pos[2];
      scale = clip((fl64 * 4096 + den / 2) / den, 0, 65535);
      v.visible = 1'b1;
      v.sx = project_axis(ball_pos[0], scale, longint'(ScreenWidth) * 32);
      v.sy = project_axis(ball_pos[1], scale, longint'(ScreenHeight) * 32);
      v.scale = ScaleW'(scale);
    end else begin
      v.visible = 1'b0;
      v.sx = '0;
      v.sy = '0;
      v.scale = '0;
    end
    v.depth = PosW'(ball_pos[2]);
    return v;
  endfunction

  // driver
  always @(posedge clk_i) begin
    ball_cmd_t c;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        predicted_views.push_back(predict_view(cur_cmd));
        gap_left = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0 || pending_cmds.size() == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end
          in_valid <= 1'b0;
        end else begin
          c = pending_cmds.pop_front();
          cur_cmd = c;
          in_valid <= 1'b1;
          action <= c.action;
          launch_vel_x <= c.vx;
          launch_vel_y <= c.vy;
          launch_vel_z <= c.vz;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ball_view_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (predicted_views.size() == 0) begin
          if (errors < 10) begin
            $display("tb_top: result item with no item pending: vis=%0b x=%0d y=%0d s=%0d z=%0d",
                     visible_o, screen_x_o, screen_y_o, draw_scale_o, depth_z_o);
          end
          errors++;
        end else begin
          want = predicted_views.pop_front();
          if (visible_o !== want.visible || screen_x_o !== want.sx ||
              screen_y_o !== want.sy || draw_scale_o !== want.scale ||
              depth_z_o !== want.depth) begin
            if (errors < 10) begin
              $display("tb_top: mismatch exp vis=%0b x=%0d y=%0d s=%0d z=%0d",
                       want.visible, want.sx, want.sy, want.scale, want.depth);
              $display("tb_top:          got vis=%0b x=%0d y=%0d s=%0d z=%0d",
                       visible_o, screen_x_o, screen_y_o, draw_scale_o, depth_z_o);
            end
            errors++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic configure(input cfg_set_t vals);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_e'(i);
      cfg_wdata <= vals[i];
      case (cfg_idx_e'(i))
        CFG_WALL_LEFT:   wall_lo[0] = vals[i];
        CFG_WALL_RIGHT:  wall_hi[0] = vals[i];
        CFG_WALL_TOP:    wall_lo[1] = vals[i];
        CFG_WALL_BOTTOM: wall_hi[1] = vals[i];
        CFG_WALL_FRONT:  wall_lo[2] = vals[i];
        CFG_WALL_BACK:   wall_hi[2] = vals[i];
        CFG_RADIUS:      radius_q = vals[i][RadW-1:0];
        CFG_FOCAL:       focal_q = vals[i];
        default: ;
      endcase
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_cmd(input logic act, input logic [VelInW-1:0] vx,
                          input logic [VelInW-1:0] vy, input logic [VelInW-1:0] vz);
    ball_cmd_t c;
    c.action = act;
    c.vx = vx;
    c.vy = vy;
    c.vz = vz;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || predicted_views.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    cfg_set_t vals;
    int       wall_v;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: launches at the velocity extremes, then bounces
    push_cmd(ACT_LAUNCH, 10'(511), 10'(-512), 10'(1));
    repeat (8) push_cmd(ACT_TICK, 10'($urandom), 10'($urandom), 10'($urandom));
    push_cmd(ACT_LAUNCH, 10'(-512), 10'(511), 10'(-512));
    repeat (4) push_cmd(ACT_TICK, '0, '0, '0);
    wait_drained();

    // widest box, zero radius, longest focal length
    vals = '{10'(-511), 10'(511), 10'(-511), 10'(511), 10'(-511), 10'(511),
             10'h300, 10'(1023)};
    configure(vals);
    push_cmd(ACT_LAUNCH, 10'(511), 10'(511), 10'(511));
    repeat (3) push_cmd(ACT_TICK, 10'h3FF, 10'h3FF, 10'h3FF);
    wait_drained();

    // inverted walls, largest radius, focal of one: clamps saturate, ball hidden
    vals = '{10'(511), 10'(-511), 10'(511), 10'(-511), 10'(511), 10'(-511),
             10'(255), 10'(1)};
    configure(vals);
    repeat (2) push_cmd(ACT_TICK, '0, '0, '0);
    wait_drained();

    // focal length of zero
    vals = '{10'(-100), 10'(100), 10'(-100), 10'(100), 10'(-100), 10'(100),
             10'(10), 10'(0)};
    configure(vals);
    push_cmd(ACT_LAUNCH, 10'(0), 10'(0), 10'(5));
    repeat (2) push_cmd(ACT_TICK, '0, '0, '0);
    push_cmd(ACT_LAUNCH, 10'(0), 10'(0), 10'(-5));
    push_cmd(ACT_TICK, '0, '0, '0);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 8; i++) begin
          vals[i] = CfgW'($urandom);
        end
      end else begin
        for (int a = 0; a < 3; a++) begin
          wall_v = -int'($urandom_range(40, 511));
          vals[2 * a] = CfgW'(wall_v);
          vals[2 * a + 1] = CfgW'($urandom_range(40, 511));
        end
        vals[6] = {2'($urandom), 8'($urandom_range(0, 40))};
        vals[7] = CfgW'($urandom_range(0, 1023));
      end
      configure(vals);
      no_idle = ($urandom_range(0, 3) == 0);
      push_cmd(ACT_LAUNCH, 10'($urandom), 10'($urandom), 10'($urandom));
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        push_cmd(($urandom_range(0, 23) == 0) ? ACT_LAUNCH : ACT_TICK,
                 10'($urandom), 10'($urandom), 10'($urandom));
      end
      wait_drained();
    end

    no_idle = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
